@@ rtl/shw_pkg.sv @@
package shw_pkg;

    localparam int FRAC_BITS = 16;
    localparam int ROT_FRAC  = 14;
    localparam int DW        = 32;
    localparam int ROT_W     = 16;
    localparam int CFG_W     = 48;
    localparam int CFG_IDX_W = 3;
    localparam int PR_W      = DW + ROT_W;
    localparam int XW        = DW + FRAC_BITS;
    localparam int SQW       = XW / 2;
    localparam int HW        = FRAC_BITS + 1;
    localparam int ZN_W      = 2 * FRAC_BITS + 1;
    localparam int WN_W      = HW + FRAC_BITS;

    localparam logic [CFG_IDX_W-1:0] REG_ROT0    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROT1    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROT2    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NOISE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HUBER   = 3'd6;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZDG  = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;
    localparam logic [1:0] ST_SAT  = 2'd3;

    typedef struct packed {
        logic signed [31:0] residual;
        logic signed [31:0] grad_x;
        logic signed [31:0] grad_y;
        logic signed [31:0] cur_point_x;
        logic signed [31:0] cur_point_y;
        logic signed [31:0] cur_point_z;
        logic signed [31:0] ref_point_x;
        logic signed [31:0] ref_point_y;
        logic signed [31:0] ref_point_z;
        logic signed [31:0] disparity;
        logic signed [31:0] disparity_grad;
    } t_in;

    typedef struct packed {
        logic [31:0] weight;
        logic [1:0]  status;
    } t_out;

    typedef struct packed {
        t_in                   pix;
        logic                  zdg;
        logic                  zdz;
        logic                  sat;
        logic [DW-1:0]         fxg;
        logic [DW-1:0]         fyg;
        logic [DW-1:0]         zinv;
        logic [DW-1:0]         tsum;
        logic [DW-1:0]         l0;
        logic [DW-1:0]         l1;
        logic [DW-1:0]         mz;
        logic [DW-1:0]         l2;
        logic [DW-1:0]         a;
        logic [DW-1:0]         d;
        logic [DW-1:0]         q;
        logic [DW-1:0]         q2;
        logic [DW-1:0]         s2;
        logic [63:0]           p1;
        logic [63:0]           p2;
        logic [63:0]           pl0;
        logic [63:0]           pl1;
        logic [63:0]           pm;
        logic [63:0]           pl2;
        logic [63:0]           qq;
        logic [63:0]           pt;
        logic [8:0][PR_W-1:0]  pr;
        logic [2:0][DW-1:0]    v;
        logic [2:0][63:0]      pv;
        logic                  s2z;
        logic [SQW-1:0]        sig;
        logic [XW-1:0]         x;
        logic [HW-1:0]         h;
    } t_ctx;

    function automatic logic ovf_s(input logic signed [63:0] v);
        return v[63:31] != {33{v[31]}};
    endfunction

    function automatic logic [31:0] sat_s(input logic signed [63:0] v);
        if (ovf_s(v)) begin
            return v[63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        return v[31:0];
    endfunction

    function automatic logic ovf_u(input logic [63:0] v);
        return |v[63:32];
    endfunction

    function automatic logic [31:0] sat_u(input logic [63:0] v);
        return ovf_u(v) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function automatic logic [31:0] abs32(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    function automatic logic signed [63:0] smag(input logic [63:0] m, input logic neg);
        return neg ? -$signed(m) : $signed(m);
    endfunction

endpackage

@@ rtl/shw_udiv.sv @@
module shw_udiv #(
    parameter int NUM_W  = 32,
    parameter int DEN_W  = 32,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [NUM_W-1:0]  o_quo,
    output logic [SIDE_W-1:0] o_side
);

    // one quotient bit per stage; numerator shifts out as quotient shifts in
    logic              r_vld  [NUM_W];
    logic [DEN_W-1:0]  r_rem  [NUM_W];
    logic [NUM_W-1:0]  r_nq   [NUM_W];
    logic [DEN_W-1:0]  r_den  [NUM_W];
    logic [SIDE_W-1:0] r_side [NUM_W];

    genvar k;
    generate
        for (k = 0; k < NUM_W; k++) begin : g_stage
            logic              p_v;
            logic [DEN_W-1:0]  p_rem;
            logic [NUM_W-1:0]  p_nq;
            logic [DEN_W-1:0]  p_den;
            logic [SIDE_W-1:0] p_side;
            logic [DEN_W:0]    sh;
            logic [DEN_W:0]    df;
            logic              ge;

            if (k == 0) begin : g_first
                assign p_v    = i_valid;
                assign p_rem  = '0;
                assign p_nq   = i_num;
                assign p_den  = i_den;
                assign p_side = i_side;
            end else begin : g_next
                assign p_v    = r_vld[k-1];
                assign p_rem  = r_rem[k-1];
                assign p_nq   = r_nq[k-1];
                assign p_den  = r_den[k-1];
                assign p_side = r_side[k-1];
            end

            assign sh = {p_rem, p_nq[NUM_W-1]};
            assign ge = sh >= {1'b0, p_den};
            assign df = sh - {1'b0, p_den};

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else begin
                    r_vld[k] <= p_v;
                end
            end

            always_ff @(posedge i_clk) begin
                r_rem[k]  <= ge ? df[DEN_W-1:0] : sh[DEN_W-1:0];
                r_nq[k]   <= {p_nq[NUM_W-2:0], ge};
                r_den[k]  <= p_den;
                r_side[k] <= p_side;
            end
        end
    endgenerate

    assign o_valid = r_vld[NUM_W-1];
    assign o_quo   = r_nq[NUM_W-1];
    assign o_side  = r_side[NUM_W-1];

endmodule

@@ rtl/shw_usqrt.sv @@
module shw_usqrt #(
    parameter int RAD_W  = 48,
    parameter int SIDE_W = 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [RAD_W-1:0]    i_rad,
    input  logic [SIDE_W-1:0]   i_side,
    output logic                o_valid,
    output logic [RAD_W/2-1:0]  o_root,
    output logic [SIDE_W-1:0]   o_side
);

    localparam int RT_W = RAD_W / 2;

    // one root bit per stage
    logic              r_vld  [RT_W];
    logic [RT_W:0]     r_rem  [RT_W];
    logic [RT_W-1:0]   r_root [RT_W];
    logic [RAD_W-1:0]  r_rad  [RT_W];
    logic [SIDE_W-1:0] r_side [RT_W];

    genvar k;
    generate
        for (k = 0; k < RT_W; k++) begin : g_stage
            logic              p_v;
            logic [RT_W:0]     p_rem;
            logic [RT_W-1:0]   p_root;
            logic [RAD_W-1:0]  p_rad;
            logic [SIDE_W-1:0] p_side;
            logic [RT_W+2:0]   sh;
            logic [RT_W+2:0]   tr;
            logic [RT_W+2:0]   df;
            logic              ge;

            if (k == 0) begin : g_first
                assign p_v    = i_valid;
                assign p_rem  = '0;
                assign p_root = '0;
                assign p_rad  = i_rad;
                assign p_side = i_side;
            end else begin : g_next
                assign p_v    = r_vld[k-1];
                assign p_rem  = r_rem[k-1];
                assign p_root = r_root[k-1];
                assign p_rad  = r_rad[k-1];
                assign p_side = r_side[k-1];
            end

            assign sh = {p_rem, p_rad[RAD_W-1 -: 2]};
            assign tr = {1'b0, p_root, 2'b01};
            assign ge = sh >= tr;
            assign df = sh - tr;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else begin
                    r_vld[k] <= p_v;
                end
            end

            always_ff @(posedge i_clk) begin
                r_rem[k]  <= ge ? df[RT_W:0] : sh[RT_W:0];
                r_root[k] <= {p_root[RT_W-2:0], ge};
                r_rad[k]  <= {p_rad[RAD_W-3:0], 2'b00};
                r_side[k] <= p_side;
            end
        end
    endgenerate

    assign o_valid = r_vld[RT_W-1];
    assign o_root  = r_root[RT_W-1];
    assign o_side  = r_side[RT_W-1];

endmodule

@@ rtl/stereo_huber_weight.sv @@
// Stereo Huber weight: one pixel per clock in, one weight per pixel out, in order.
// A pixel is taken on any edge with start high and busy low; busy is high only in reset.
// The result shows on o_result with o_strobe for one cycle, registered from the output
// of the final weight divider in the chain below; the receiver cannot
// stall, so results must be captured when strobed.
// The latency is set by the chain of bit-serial pipelined dividers (inverse depth,
// derivative over disparity, over disparity gradient, normalized residual, Huber ratio,
// final weight) and the pipelined square root, each one bit per stage.
// Configuration registers may be written only while no pixel is in flight.
module stereo_huber_weight (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  shw_pkg::t_in                    i_in,
    output logic                            o_strobe,
    output shw_pkg::t_out                   o_result,
    input  logic                            i_cfg_we,
    input  logic [shw_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [shw_pkg::CFG_W-1:0]       i_cfg_data
);

    import shw_pkg::*;

    localparam int CTX_W = $bits(t_ctx);
    localparam logic [ZN_W-1:0] ZNUM = ZN_W'(1) << (2 * FRAC_BITS);
    localparam logic [HW-1:0]   HONE = HW'(1) << FRAC_BITS;

    logic [2:0][CFG_W-1:0] r_rot;
    logic [DW-1:0] r_focal_x, r_focal_y, r_nv, r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot[0]  <= 48'd16384;
            r_rot[1]  <= 48'd1073741824;
            r_rot[2]  <= 48'd70368744177664;
            r_focal_x <= 32'd32768000;
            r_focal_y <= 32'd32768000;
            r_nv      <= 32'd65536;
            r_thr     <= 32'd88146;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ROT0:    r_rot[0]  <= i_cfg_data;
                REG_ROT1:    r_rot[1]  <= i_cfg_data;
                REG_ROT2:    r_rot[2]  <= i_cfg_data;
                REG_FOCAL_X: r_focal_x <= i_cfg_data[DW-1:0];
                REG_FOCAL_Y: r_focal_y <= i_cfg_data[DW-1:0];
                REG_NOISE:   r_nv      <= i_cfg_data[DW-1:0];
                REG_HUBER:   r_thr     <= i_cfg_data[DW-1:0];
                default: ;
            endcase
        end
    end

    assign busy = ~i_rst_n;

    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_v8, r_v9, r_v10, r_v11, r_v12;
    logic r_v13, r_v14, r_v15, r_v16, r_v17, r_v18, r_v19, r_v20;
    t_ctx r_c1, r_c2, r_c3, r_c4, r_c5, r_c6, r_c7, r_c8, r_c9, r_c10, r_c11, r_c12;
    t_ctx r_c13, r_c14, r_c15, r_c16, r_c17, r_c18, r_c19, r_c20;
    t_ctx n_c1, n_c2, n_c3, n_c4, n_c5, n_c6, n_c7, n_c8, n_c9, n_c10, n_c11, n_c12;
    t_ctx n_c13, n_c14, n_c15, n_c16, n_c17, n_c18, n_c19, n_c20;
    logic r_strobe, n_strobe;
    t_out r_result, n_result;

    logic             dz_v, dd_v, dq_v, sq_v, dx_v, dh_v, dw_v;
    logic [ZN_W-1:0]  dz_quo;
    logic [XW-1:0]    dd_quo, dq_quo, dx_quo, dh_quo;
    logic [SQW-1:0]   sq_root;
    logic [WN_W-1:0]  dw_quo;
    logic [CTX_W-1:0] dz_side, dd_side, dq_side, sq_side, dx_side, dh_side, dw_side;
    t_ctx dz_c, dd_c, dq_c, sq_c, dx_c, dh_c, dw_c;

    assign dz_c = t_ctx'(dz_side);
    assign dd_c = t_ctx'(dd_side);
    assign dq_c = t_ctx'(dq_side);
    assign sq_c = t_ctx'(sq_side);
    assign dx_c = t_ctx'(dx_side);
    assign dh_c = t_ctx'(dh_side);
    assign dw_c = t_ctx'(dw_side);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;  r_v2 <= 1'b0;  r_v3 <= 1'b0;  r_v4 <= 1'b0;  r_v5 <= 1'b0;
            r_v6 <= 1'b0;  r_v7 <= 1'b0;  r_v8 <= 1'b0;  r_v9 <= 1'b0;  r_v10 <= 1'b0;
            r_v11 <= 1'b0; r_v12 <= 1'b0; r_v13 <= 1'b0; r_v14 <= 1'b0; r_v15 <= 1'b0;
            r_v16 <= 1'b0; r_v17 <= 1'b0; r_v18 <= 1'b0; r_v19 <= 1'b0; r_v20 <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_v1  <= start;
            r_v2  <= r_v1;
            r_v3  <= dz_v;
            r_v4  <= r_v3;
            r_v5  <= r_v4;
            r_v6  <= r_v5;
            r_v7  <= r_v6;
            r_v8  <= r_v7;
            r_v9  <= r_v8;
            r_v10 <= r_v9;
            r_v11 <= r_v10;
            r_v12 <= r_v11;
            r_v13 <= dd_v;
            r_v14 <= dq_v;
            r_v15 <= r_v14;
            r_v16 <= r_v15;
            r_v17 <= r_v16;
            r_v18 <= sq_v;
            r_v19 <= dx_v;
            r_v20 <= dh_v;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c1  <= n_c1;  r_c2  <= n_c2;  r_c3  <= n_c3;  r_c4  <= n_c4;  r_c5  <= n_c5;
        r_c6  <= n_c6;  r_c7  <= n_c7;  r_c8  <= n_c8;  r_c9  <= n_c9;  r_c10 <= n_c10;
        r_c11 <= n_c11; r_c12 <= n_c12; r_c13 <= n_c13; r_c14 <= n_c14; r_c15 <= n_c15;
        r_c16 <= n_c16; r_c17 <= n_c17; r_c18 <= n_c18; r_c19 <= n_c19; r_c20 <= n_c20;
        r_result <= n_result;
    end

    // capture, zero checks
    always_comb begin
        n_c1     = '0;
        n_c1.pix = i_in;
        n_c1.zdg = i_in.disparity_grad == '0;
        n_c1.zdz = (i_in.cur_point_z == '0) || (i_in.disparity == '0);
    end

    // gradient times focal length
    always_comb begin
        logic signed [63:0] tx, ty, sx, sy;
        tx = r_c1.pix.grad_x * $signed({1'b0, r_focal_x});
        ty = r_c1.pix.grad_y * $signed({1'b0, r_focal_y});
        sx = tx >>> FRAC_BITS;
        sy = ty >>> FRAC_BITS;
        n_c2     = r_c1;
        n_c2.fxg = sat_s(sx);
        n_c2.fyg = sat_s(sy);
        n_c2.sat = ovf_s(sx) | ovf_s(sy);
    end

    shw_udiv #(.NUM_W(ZN_W), .DEN_W(DW), .SIDE_W(CTX_W)) u_div_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v2),
        .i_num   (ZNUM),
        .i_den   (abs32(r_c2.pix.cur_point_z)),
        .i_side  (r_c2),
        .o_valid (dz_v),
        .o_quo   (dz_quo),
        .o_side  (dz_side)
    );

    always_comb begin
        logic signed [63:0] zm;
        zm = smag(64'(dz_quo), dz_c.pix.cur_point_z[31]);
        n_c3      = dz_c;
        n_c3.zinv = sat_s(zm);
        n_c3.sat  = dz_c.sat | ovf_s(zm);
        n_c3.p1   = $signed(dz_c.fxg) * dz_c.pix.cur_point_x;
        n_c3.p2   = $signed(dz_c.fyg) * dz_c.pix.cur_point_y;
    end

    always_comb begin
        logic signed [63:0] s;
        s = ($signed(r_c3.p1) >>> FRAC_BITS) + ($signed(r_c3.p2) >>> FRAC_BITS);
        n_c4      = r_c3;
        n_c4.tsum = sat_s(s);
        n_c4.sat  = r_c3.sat | ovf_s(s);
        n_c4.pl0  = $signed(r_c3.fxg) * $signed(r_c3.zinv);
        n_c4.pl1  = $signed(r_c3.fyg) * $signed(r_c3.zinv);
    end

    always_comb begin
        logic signed [63:0] s0, s1;
        s0 = $signed(r_c4.pl0) >>> FRAC_BITS;
        s1 = $signed(r_c4.pl1) >>> FRAC_BITS;
        n_c5     = r_c4;
        n_c5.l0  = sat_s(s0);
        n_c5.l1  = sat_s(s1);
        n_c5.sat = r_c4.sat | ovf_s(s0) | ovf_s(s1);
        n_c5.pm  = $signed(r_c4.zinv) * $signed(r_c4.tsum);
    end

    always_comb begin
        logic signed [63:0] s;
        s = $signed(r_c5.pm) >>> FRAC_BITS;
        n_c6     = r_c5;
        n_c6.mz  = sat_s(s);
        n_c6.sat = r_c5.sat | ovf_s(s);
    end

    always_comb begin
        n_c7     = r_c6;
        n_c7.pl2 = $signed(r_c6.mz) * $signed(r_c6.zinv);
    end

    always_comb begin
        logic signed [63:0] s;
        s = $signed(r_c7.pl2) >>> FRAC_BITS;
        n_c8     = r_c7;
        n_c8.l2  = sat_s(s);
        n_c8.sat = r_c7.sat | ovf_s(s);
    end

    // row vector times rotation: nine products
    always_comb begin
        logic signed [PR_W-1:0] p;
        logic [2:0][DW-1:0] l;
        l = {r_c8.l2, r_c8.l1, r_c8.l0};
        n_c9 = r_c8;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                p = $signed(l[i]) * $signed(r_rot[i][ROT_W*j +: ROT_W]);
                n_c9.pr[3*i+j] = p;
            end
        end
    end

    always_comb begin
        logic signed [63:0] e0, e1, e2, s;
        n_c10 = r_c9;
        for (int j = 0; j < 3; j++) begin
            e0 = $signed(r_c9.pr[j]);
            e1 = $signed(r_c9.pr[3+j]);
            e2 = $signed(r_c9.pr[6+j]);
            s  = (e0 + e1 + e2) >>> ROT_FRAC;
            n_c10.v[j] = sat_s(s);
            n_c10.sat  = n_c10.sat | ovf_s(s);
        end
    end

    always_comb begin
        n_c11 = r_c10;
        n_c11.pv[0] = $signed(r_c10.v[0]) * r_c10.pix.ref_point_x;
        n_c11.pv[1] = $signed(r_c10.v[1]) * r_c10.pix.ref_point_y;
        n_c11.pv[2] = $signed(r_c10.v[2]) * r_c10.pix.ref_point_z;
    end

    always_comb begin
        logic signed [63:0] s;
        s = ($signed(r_c11.pv[0]) >>> FRAC_BITS) + ($signed(r_c11.pv[1]) >>> FRAC_BITS)
          + ($signed(r_c11.pv[2]) >>> FRAC_BITS);
        n_c12     = r_c11;
        n_c12.a   = sat_s(s);
        n_c12.sat = r_c11.sat | ovf_s(s);
    end

    shw_udiv #(.NUM_W(XW), .DEN_W(DW), .SIDE_W(CTX_W)) u_div_d (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v12),
        .i_num   ({abs32(r_c12.a), FRAC_BITS'(0)}),
        .i_den   (abs32(r_c12.pix.disparity)),
        .i_side  (r_c12),
        .o_valid (dd_v),
        .o_quo   (dd_quo),
        .o_side  (dd_side)
    );

    always_comb begin
        logic signed [63:0] s;
        s = smag(64'(dd_quo), dd_c.a[31] ^ dd_c.pix.disparity[31]);
        n_c13     = dd_c;
        n_c13.d   = sat_s(s);
        n_c13.sat = dd_c.sat | ovf_s(s);
    end

    shw_udiv #(.NUM_W(XW), .DEN_W(DW), .SIDE_W(CTX_W)) u_div_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v13),
        .i_num   ({abs32(r_c13.d), FRAC_BITS'(0)}),
        .i_den   (abs32(r_c13.pix.disparity_grad)),
        .i_side  (r_c13),
        .o_valid (dq_v),
        .o_quo   (dq_quo),
        .o_side  (dq_side)
    );

    always_comb begin
        logic signed [63:0] s;
        logic [DW-1:0] qv;
        s  = smag(64'(dq_quo), dq_c.d[31] ^ dq_c.pix.disparity_grad[31]);
        qv = sat_s(s);
        n_c14     = dq_c;
        n_c14.q   = qv;
        n_c14.sat = dq_c.sat | ovf_s(s);
        n_c14.qq  = $signed(qv) * $signed(qv);
    end

    always_comb begin
        logic [63:0] s;
        s = r_c14.qq >> FRAC_BITS;
        n_c15     = r_c14;
        n_c15.q2  = sat_u(s);
        n_c15.sat = r_c14.sat | ovf_u(s);
    end

    always_comb begin
        n_c16    = r_c15;
        n_c16.pt = 64'(r_nv) * 64'(r_c15.q2);
    end

    always_comb begin
        logic [63:0] s, u;
        logic [DW-1:0] tm;
        s  = r_c16.pt >> FRAC_BITS;
        tm = sat_u(s);
        u  = 64'(r_nv) + 64'(tm);
        n_c17     = r_c16;
        n_c17.s2  = sat_u(u);
        n_c17.s2z = sat_u(u) == '0;
        n_c17.sat = r_c16.sat | ovf_u(s) | ovf_u(u);
    end

    shw_usqrt #(.RAD_W(XW), .SIDE_W(CTX_W)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v17),
        .i_rad   ({r_c17.s2, FRAC_BITS'(0)}),
        .i_side  (r_c17),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    always_comb begin
        n_c18     = sq_c;
        n_c18.sig = sq_root;
    end

    shw_udiv #(.NUM_W(XW), .DEN_W(SQW), .SIDE_W(CTX_W)) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v18),
        .i_num   ({abs32(r_c18.pix.residual), FRAC_BITS'(0)}),
        .i_den   (r_c18.sig),
        .i_side  (r_c18),
        .o_valid (dx_v),
        .o_quo   (dx_quo),
        .o_side  (dx_side)
    );

    always_comb begin
        n_c19   = dx_c;
        n_c19.x = dx_quo;
    end

    shw_udiv #(.NUM_W(XW), .DEN_W(XW), .SIDE_W(CTX_W)) u_div_h (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v19),
        .i_num   ({r_thr, FRAC_BITS'(0)}),
        .i_den   (r_c19.x),
        .i_side  (r_c19),
        .o_valid (dh_v),
        .o_quo   (dh_quo),
        .o_side  (dh_side)
    );

    // inside the threshold the weight factor is one
    always_comb begin
        n_c20   = dh_c;
        n_c20.h = (dh_c.x <= XW'(r_thr)) ? HONE : dh_quo[HW-1:0];
    end

    shw_udiv #(.NUM_W(WN_W), .DEN_W(DW), .SIDE_W(CTX_W)) u_div_w (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v20),
        .i_num   ({r_c20.h, FRAC_BITS'(0)}),
        .i_den   (r_c20.s2),
        .i_side  (r_c20),
        .o_valid (dw_v),
        .o_quo   (dw_quo),
        .o_side  (dw_side)
    );

    always_comb begin
        n_strobe = dw_v;
        if (dw_c.zdg) begin
            n_result.weight = '0;
            n_result.status = ST_ZDG;
        end else if (dw_c.zdz) begin
            n_result.weight = '0;
            n_result.status = ST_ZERO;
        end else if (dw_c.s2z) begin
            n_result.weight = '1;
            n_result.status = ST_SAT;
        end else begin
            n_result.weight = sat_u(64'(dw_quo));
            n_result.status = (dw_c.sat | ovf_u(64'(dw_quo))) ? ST_SAT : ST_OK;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    a_valid_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 == $past(r_v1))
        else $error("pipeline valid lost between capture stages");

    a_zdg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.status == ST_ZDG |-> o_result.weight == '0)
        else $error("zero disparity gradient with nonzero weight");

    a_sqrt_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v18 && r_c18.s2z |-> r_c18.sig == '0)
        else $error("root of zero variance not zero");

    a_h_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v20 |-> r_c20.h <= HONE)
        else $error("huber factor above one");

endmodule
